// ----- rtl/bal_pkg.sv -----
// Shared constants, types and codes of the bounded array list.
`default_nettype none

package bal_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int POS_W  = 5;
    localparam int CAP_W  = 5;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS  = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_HEAD = 3'd3;
    localparam logic [OP_W-1:0] OP_REM_TAIL = 3'd4;

    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [CMP_W-1:0]         cmp_t;
    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    typedef struct packed {
        logic  we;
        addr_t waddr;
        data_t wdata;
        logic  re;
        addr_t raddr;
    } mem_req_t;

    typedef struct packed {
        logic  ok;
        data_t value;
    } res_t;

endpackage

`default_nettype wire

// ----- rtl/bal_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none

module bal_ram #(
    parameter int AW = 4,
    parameter int DW = 32
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem_reg [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/bal_ctrl.sv -----
// Request decode, shift sequencer, count and capacity of the list.
`default_nettype none

module bal_ctrl
    import bal_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write_en,
    input  wire logic [CAP_W-1:0]  cfg_write_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [OP_W-1:0]   op,
    input  wire logic [POS_W-1:0]  position,
    input  wire data_t             value_in,
    output mem_req_t               mem_req,
    input  wire data_t             rdata,
    output logic                   res_valid,
    input  wire logic              res_take,
    output res_t                   res
);

    state_t            state_reg, state_next;
    cnt_t              count_reg, count_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic              more_reg, more_next;
    logic              pend_reg, pend_next;
    logic              first_reg, first_next;
    logic              ins_reg, ins_next;
    addr_t             ptr_reg, ptr_next;
    addr_t             end_reg, end_next;
    addr_t             last_reg, last_next;
    data_t             v_reg, v_next;
    data_t             value_reg, value_next;
    logic              ok_reg, ok_next;

    cmp_t   lim;
    cmp_t   count_ext;
    logic   full;
    logic   empty;
    logic   pos_ok;
    logic   ins_ok;
    addr_t  ins_idx;
    addr_t  cnt_m1;

    always_comb
    begin
        count_ext = cmp_t'(count_reg);
        lim       = (cmp_t'(cap_reg) > cmp_t'(DEPTH)) ? cmp_t'(DEPTH) : cmp_t'(cap_reg);
        full      = (count_ext >= lim);
        empty     = (count_reg == '0);
        pos_ok    = (position != '0) && (cmp_t'(position) <= count_ext + cmp_t'(1));
        cnt_m1    = addr_t'(count_reg - 1'b1);
        case (op)
            OP_INS_HEAD:
            begin
                ins_idx = '0;
                ins_ok  = !full;
            end
            OP_INS_TAIL:
            begin
                ins_idx = addr_t'(count_reg);
                ins_ok  = !full;
            end
            OP_INS_POS:
            begin
                ins_idx = addr_t'(position - 1'b1);
                ins_ok  = !full && pos_ok;
            end
            default:
            begin
                ins_idx = '0;
                ins_ok  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cap_next   = cfg_write_en ? cfg_write_data : cap_reg;
        more_next  = more_reg;
        pend_next  = pend_reg;
        first_next = first_reg;
        ins_next   = ins_reg;
        ptr_next   = ptr_reg;
        end_next   = end_reg;
        last_next  = last_reg;
        v_next     = v_reg;
        value_next = value_reg;
        ok_next    = ok_reg;
        mem_req    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    v_next     = value_in;
                    value_next = '0;
                    pend_next  = 1'b0;
                    first_next = 1'b0;
                    ins_next   = 1'b1;
                    ptr_next   = cnt_m1;
                    end_next   = cnt_m1;
                    case (op)
                        OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS:
                        begin
                            ok_next    = ins_ok;
                            end_next   = ins_idx;
                            more_next  = ins_ok && (cnt_t'(ins_idx) < count_reg);
                            state_next = ins_ok ? S_RUN : S_DONE;
                        end
                        OP_REM_HEAD:
                        begin
                            ins_next   = 1'b0;
                            ok_next    = !empty;
                            ptr_next   = '0;
                            more_next  = !empty;
                            first_next = 1'b1;
                            state_next = empty ? S_DONE : S_RUN;
                        end
                        OP_REM_TAIL:
                        begin
                            ins_next   = 1'b0;
                            ok_next    = !empty;
                            more_next  = !empty;
                            first_next = 1'b1;
                            state_next = empty ? S_DONE : S_RUN;
                        end
                        default:
                        begin
                            ok_next    = 1'b0;
                            more_next  = 1'b0;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                if (more_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ptr_reg;
                    last_next     = ptr_reg;
                    pend_next     = 1'b1;
                    if (ptr_reg == end_reg)
                    begin
                        more_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = ins_reg ? addr_t'(ptr_reg - 1'b1) : addr_t'(ptr_reg + 1'b1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    if (ins_reg)
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = addr_t'(last_reg + 1'b1);
                        mem_req.wdata = rdata;
                    end
                    else if (first_reg)
                    begin
                        value_next = rdata;
                        first_next = 1'b0;
                    end
                    else
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = addr_t'(last_reg - 1'b1);
                        mem_req.wdata = rdata;
                    end
                end

                if (!more_reg && !pend_reg)
                begin
                    if (ins_reg)
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = end_reg;
                        mem_req.wdata = v_reg;
                        count_next    = cnt_t'(count_reg + 1'b1);
                    end
                    else
                    begin
                        count_next = cnt_t'(count_reg - 1'b1);
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
            more_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            first_reg <= 1'b0;
            ins_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
            more_reg  <= more_next;
            pend_reg  <= pend_next;
            first_reg <= first_next;
            ins_reg   <= ins_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        end_reg   <= end_next;
        last_reg  <= last_next;
        v_reg     <= v_next;
        value_reg <= value_next;
        ok_reg    <= ok_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.ok    = ok_reg;
    assign res.value = value_reg;

    // shift order never reads the entry being written
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.re && mem_req.we && (mem_req.raddr == mem_req.waddr)))
        else $error("bal_ctrl: read and write of the same entry in one cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(DEPTH))
        else $error("bal_ctrl: count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_RUN))
        else $error("bal_ctrl: count changed outside a shift sequence");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) && !more_reg && !pend_reg |=> (state_reg == S_DONE))
        else $error("bal_ctrl: sequence did not finish");

endmodule

`default_nettype wire

// ----- rtl/bounded_array_list.sv -----
// Bounded array list: top level with entry store, sequencer and result register.
//
// Requests arrive on in_valid/in_stall with op, position and value_in; each
// transfer yields exactly one result on out_valid/out_stall carrying ok and
// value_out. capacity is set through cfg_write_en/cfg_write_data; the user
// must write it only while idle, which the block itself does not enforce.
// Entries live in a 16 x 32 RAM with one write and one read port; shifts
// move one entry per cycle through that pair of ports. A shift reads
// entries one at a time: an insert at index i reads count - i entries,
// a head removal reads all count entries and a tail removal reads one.
// One request is in the sequencer at a time; a new request is taken the
// cycle after the previous result has moved into the output register, even
// while that register is stalled.
// Reset empties the list and sets capacity to 16; the RAM is not cleared.
// While out_stall is high and a result is waiting, the result holds and the
// sequencer waits with its own finished result before taking more requests.
`default_nettype none

module bounded_array_list
    import bal_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write_en,
    input  wire logic [CAP_W-1:0]  cfg_write_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [OP_W-1:0]   op,
    input  wire logic [POS_W-1:0]  position,
    input  wire logic signed [DATA_W-1:0] value_in,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   ok,
    output logic signed [DATA_W-1:0] value_out
);

    mem_req_t mem_req;
    data_t    rdata;
    logic     res_valid;
    logic     res_take;
    res_t     res;

    logic     out_valid_reg, out_valid_next;
    res_t     out_res_reg;

    bal_ram #(
        .AW (ADDR_W),
        .DW (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rdata)
    );

    bal_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .position       (position),
        .value_in       (value_in),
        .mem_req        (mem_req),
        .rdata          (rdata),
        .res_valid      (res_valid),
        .res_take       (res_take),
        .res            (res)
    );

    assign res_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = out_res_reg.ok;
    assign value_out = out_res_reg.value;

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for the bounded array list: directed table, then random phases.
`timescale 1ns / 100ps

module tb_top
    import bal_pkg::*;
();

    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        bit               is_cfg;
        logic [CAP_W-1:0] cap;
        logic [OP_W-1:0]  opc;
        logic [POS_W-1:0] pos;
        data_t            val;
        bit               typed;
        res_t             want;
    } step_t;

    localparam int NUM_STEPS = 29;

    // typed rows carry their result; the rest go through the list predictor
    localparam step_t SCRIPT [NUM_STEPS] = '{
        '{1'b0, 5'd0,  OP_REM_HEAD, 5'd0,  32'sd0,          1'b1, '{1'b0, 32'sd0}},
        '{1'b0, 5'd0,  OP_REM_TAIL, 5'd0,  32'sd0,          1'b1, '{1'b0, 32'sd0}},
        '{1'b0, 5'd0,  OP_INS_POS,  5'd0,  32'sd7,          1'b1, '{1'b0, 32'sd0}},
        '{1'b0, 5'd0,  OP_INS_POS,  5'd2,  32'sd9,          1'b1, '{1'b0, 32'sd0}},
        '{1'b0, 5'd0,  OP_INS_TAIL, 5'd0,  32'sh7FFFFFFF,   1'b1, '{1'b1, 32'sd0}},
        '{1'b0, 5'd0,  OP_INS_HEAD, 5'd0,  32'sh80000000,   1'b1, '{1'b1, 32'sd0}},
        '{1'b0, 5'd0,  OP_INS_POS,  5'd2,  -32'sd1,         1'b0, '{1'b0, 32'sd0}},
        '{1'b0, 5'd0,  OP_INS_POS,  5'd4,  32'sh5A5A5A5A,   1'b0, '{1'b0, 32'sd0}},
        '{1'b0, 5'd0,  OP_INS_POS,  5'd31, 32'sd3,          1'b1, '{1'b0, 32'sd0}},
        '{1'b0, 5'd0,  OP_SPARE_5,  5'd1,  32'sd5,          1'b1, '{1'b0, 32'sd0}},
        '{1'b0, 5'd0,  OP_SPARE_6,  5'd1,  32'sd6,          1'b1, '{1'b0, 32'sd0}},
        '{1'b0, 5'd0,  OP_SPARE_7,  5'd1,  32'sd7,          1'b1, '{1'b0, 32'sd0}},
        '{1'b0, 5'd0,  OP_REM_HEAD, 5'd0,  32'sd0,          1'b1, '{1'b1, 32'sh80000000}},
        '{1'b0, 5'd0,  OP_REM_TAIL, 5'd0,  32'sd0,          1'b0, '{1'b0, 32'sd0}},
        '{1'b1, 5'd2,  OP_INS_HEAD, 5'd0,  32'sd0,          1'b0, '{1'b0, 32'sd0}},
        '{1'b0, 5'd0,  OP_INS_HEAD, 5'd0,  32'sd1,          1'b1, '{1'b0, 32'sd0}},
        '{1'b0, 5'd0,  OP_INS_POS,  5'd1,  32'sd2,          1'b1, '{1'b0, 32'sd0}},
        '{1'b1, 5'd1,  OP_INS_HEAD, 5'd0,  32'sd0,          1'b0, '{1'b0, 32'sd0}},
        '{1'b0, 5'd0,  OP_INS_TAIL, 5'd0,  32'sd3,          1'b1, '{1'b0, 32'sd0}},
        '{1'b0, 5'd0,  OP_REM_TAIL, 5'd0,  32'sd0,          1'b0, '{1'b0, 32'sd0}},
        '{1'b0, 5'd0,  OP_INS_HEAD, 5'd0,  32'sd4,          1'b1, '{1'b0, 32'sd0}},
        '{1'b0, 5'd0,  OP_REM_HEAD, 5'd0,  32'sd0,          1'b0, '{1'b0, 32'sd0}},
        '{1'b0, 5'd0,  OP_INS_TAIL, 5'd0,  32'sh00001234,   1'b1, '{1'b1, 32'sd0}},
        '{1'b1, 5'd0,  OP_INS_HEAD, 5'd0,  32'sd0,          1'b0, '{1'b0, 32'sd0}},
        '{1'b0, 5'd0,  OP_INS_TAIL, 5'd0,  32'sd8,          1'b1, '{1'b0, 32'sd0}},
        '{1'b0, 5'd0,  OP_REM_TAIL, 5'd0,  32'sd0,          1'b1, '{1'b1, 32'sh00001234}},
        '{1'b0, 5'd0,  OP_REM_HEAD, 5'd0,  32'sd0,          1'b1, '{1'b0, 32'sd0}},
        '{1'b1, 5'd31, OP_INS_HEAD, 5'd0,  32'sd0,          1'b0, '{1'b0, 32'sd0}},
        '{1'b0, 5'd0,  OP_INS_POS,  5'd1,  32'shC3C3C3C3,   1'b0, '{1'b0, 32'sd0}}
    };

    logic             clk;
    logic             rst_n;
    logic             cfg_write_en;
    logic [CAP_W-1:0] cfg_write_data;
    logic             in_valid;
    logic             in_stall;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] position;
    data_t            value_in;
    logic             out_valid;
    logic             out_stall;
    logic             ok;
    data_t            value_out;

    data_t            held_words[$];
    logic [CAP_W-1:0] cap_now;
    res_t             pending_results[$];
    int               mismatch_cnt;
    int               idle_pct;
    int               stall_pct;

    bounded_array_list uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .position       (position),
        .value_in       (value_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ok             (ok),
        .value_out      (value_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic res_t apply_request(input logic [OP_W-1:0] o,
                                           input logic [POS_W-1:0] p, input data_t v);
        res_t r;
        int   lim;
        r   = '0;
        lim = (int'(cap_now) > DEPTH) ? DEPTH : int'(cap_now);
        case (o)
            OP_INS_HEAD:
                if (held_words.size() < lim)
                begin
                    held_words.push_front(v);
                    r.ok = 1'b1;
                end
            OP_INS_TAIL:
                if (held_words.size() < lim)
                begin
                    held_words.push_back(v);
                    r.ok = 1'b1;
                end
            OP_INS_POS:
                if (held_words.size() < lim && int'(p) >= 1 && int'(p) <= held_words.size() + 1)
                begin
                    held_words.insert(int'(p) - 1, v);
                    r.ok = 1'b1;
                end
            OP_REM_HEAD:
                if (held_words.size() > 0)
                begin
                    r.value = held_words.pop_front();
                    r.ok    = 1'b1;
                end
            OP_REM_TAIL:
                if (held_words.size() > 0)
                begin
                    r.value = held_words.pop_back();
                    r.ok    = 1'b1;
                end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result: ok=%0b value_out=%0d", ok, value_out);
            end
            else
            begin
                want = pending_results.pop_front();
                if (ok !== want.ok || value_out !== want.value)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: expected ok=%0b value_out=%0d, got ok=%0b value_out=%0d",
                                 want.ok, want.value, ok, value_out);
                end
            end
        end
    end

    // one request transfer; called on a rising edge
    task automatic send_request(input logic [OP_W-1:0] o, input logic [POS_W-1:0] p,
                                input data_t v, input bit typed, input res_t want);
        res_t predicted;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        position <= p;
        value_in <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = apply_request(o, p, v);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_list_idle;
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 4)
            @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] c);
        wait_list_idle();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= c;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        cap_now = c;
    endtask

    task automatic random_request(input int ins_pct);
        logic [OP_W-1:0]  o;
        logic [POS_W-1:0] p;
        data_t            v;
        if ($urandom_range(0, 99) < 3)
            o = OP_W'($urandom_range(OP_SPARE_5, OP_SPARE_7));
        else if ($urandom_range(0, 99) < ins_pct)
            case ($urandom_range(0, 2))
                0:       o = OP_INS_HEAD;
                1:       o = OP_INS_TAIL;
                default: o = OP_INS_POS;
            endcase
        else
            o = $urandom_range(0, 1) ? OP_REM_HEAD : OP_REM_TAIL;
        if ($urandom_range(0, 99) < 80)
            p = POS_W'($urandom_range(1, held_words.size() + 1));
        else
            p = POS_W'($urandom);
        case ($urandom_range(0, 9))
            0:       v = 32'sh7FFFFFFF;
            1:       v = 32'sh80000000;
            2:       v = 32'sd0;
            3:       v = -32'sd1;
            default: v = data_t'($urandom);
        endcase
        send_request(o, p, v, 1'b0, '0);
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] c, input int n, input int ins_pct);
        set_capacity(c);
        repeat (n)
            random_request(ins_pct);
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= '0;
        in_valid       <= 1'b0;
        op             <= OP_INS_HEAD;
        position       <= '0;
        value_in       <= '0;
        cap_now        = CAP_RESET;
        mismatch_cnt   = 0;
        idle_pct       = 29;
        stall_pct      = 29;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (SCRIPT[i])
        begin
            if (SCRIPT[i].is_cfg)
                set_capacity(SCRIPT[i].cap);
            else
                send_request(SCRIPT[i].opc, SCRIPT[i].pos, SCRIPT[i].val,
                             SCRIPT[i].typed, SCRIPT[i].want);
        end

        run_phase(5'd16, 120, 70);
        run_phase(5'd16, 80, 25);
        idle_pct  = 0;
        stall_pct = 0;
        run_phase(5'd31, 100, 65);
        idle_pct  = 29;
        stall_pct = 29;
        // capacity drops below the count held
        run_phase(5'd5, 60, 50);
        run_phase(5'd1, 40, 50);
        run_phase(5'd0, 20, 50);
        run_phase(5'd17, 100, 60);
        repeat (6)
            run_phase(CAP_W'($urandom_range(0, 31)), 40, $urandom_range(30, 75));

        wait_list_idle();
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/bal_pkg.sv
rtl/bal_ram.sv
rtl/bal_ctrl.sv
rtl/bounded_array_list.sv
test/tb_top.sv
